// ===== hw/rtl/serial_frame_parser_defines.svh =====
// ---------------------------------------------------------------------------
// Serial frame parser assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_PARSER_DEFINES_SVH
`define SERIAL_FRAME_PARSER_DEFINES_SVH

// same-cycle implication
`define SFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sfp_pkg.sv =====
// ---------------------------------------------------------------------------
// Serial frame parser package
// Types, register map and fixed codes shared by the parser modules.
// ---------------------------------------------------------------------------
package sfp_pkg;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_NEGOTIATION_TOPIC = 3'd0;
    localparam logic [2:0] REG_TIME_TOPIC        = 3'd1;
    localparam logic [2:0] REG_PARAM_TOPIC       = 3'd2;
    localparam logic [2:0] REG_RECEIVER_COUNT    = 3'd3;
    localparam logic [2:0] REG_PAYLOAD_LIMIT     = 3'd4;
    localparam logic [2:0] REG_TIMEOUT_MS        = 3'd5;

    localparam logic [15:0] RST_NEGOTIATION_TOPIC = 16'd0;
    localparam logic [15:0] RST_TIME_TOPIC        = 16'd10;
    localparam logic [15:0] RST_PARAM_TOPIC       = 16'd6;
    localparam logic [5:0]  RST_RECEIVER_COUNT    = 6'd0;
    localparam logic [9:0]  RST_PAYLOAD_LIMIT     = 10'd512;
    localparam logic [15:0] RST_TIMEOUT_MS        = 16'd20;

    localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
    localparam logic [7:0]  CHECK_GOOD = 8'hFF;
    localparam logic [15:0] SUB_BASE   = 16'd100;
    localparam logic [15:0] ERR_MAX    = 16'hFFFF;

    localparam logic MODE_POLL = 1'b0;
    localparam logic MODE_BYTE = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    localparam logic [2:0] ROUTE_NEGOTIATION = 3'd0;
    localparam logic [2:0] ROUTE_TIME        = 3'd1;
    localparam logic [2:0] ROUTE_PARAM       = 3'd2;
    localparam logic [2:0] ROUTE_SUBSCRIBER  = 3'd3;
    localparam logic [2:0] ROUTE_UNKNOWN     = 3'd4;

    typedef enum logic [7:0] {
        PH_SYNC1    = 8'b0000_0001,
        PH_SYNC2    = 8'b0000_0010,
        PH_TOPIC_LO = 8'b0000_0100,
        PH_TOPIC_HI = 8'b0000_1000,
        PH_LEN_LO   = 8'b0001_0000,
        PH_LEN_HI   = 8'b0010_0000,
        PH_DATA     = 8'b0100_0000,
        PH_CHECK    = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [15:0] negotiation_topic;
        logic [15:0] time_topic;
        logic [15:0] param_topic;
        logic [5:0]  receiver_count;
        logic [9:0]  payload_limit;
        logic [15:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [8:0]  byte_index;
        logic [15:0] frame_topic;
        logic [9:0]  frame_length;
        logic        checksum_ok;
        logic [2:0]  route;
        logic [4:0]  subscriber_slot;
        logic [15:0] errors_seen;
        logic        link_connected;
    } result_t;

endpackage

// ===== hw/rtl/sfp_byte_if.sv =====
// ---------------------------------------------------------------------------
// Serial frame parser input channel
// Valid/ready channel carrying one poll or received byte per request.
// ---------------------------------------------------------------------------
interface sfp_byte_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  data_byte;
    logic [31:0] now_ms;

    modport source (output valid, output mode, output data_byte, output now_ms,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input now_ms,
                    output ready);
endinterface

// ===== hw/rtl/sfp_result_if.sv =====
// ---------------------------------------------------------------------------
// Serial frame parser result channel
// Valid/ready channel carrying payload bytes and end-of-frame reports.
// ---------------------------------------------------------------------------
interface sfp_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [8:0]  byte_index;
    logic [15:0] frame_topic;
    logic [9:0]  frame_length;
    logic        checksum_ok;
    logic [2:0]  route;
    logic [4:0]  subscriber_slot;
    logic [15:0] errors_seen;
    logic        link_connected;

    modport source (output valid, output kind, output payload_byte, output byte_index,
                    output frame_topic, output frame_length, output checksum_ok,
                    output route, output subscriber_slot, output errors_seen,
                    output link_connected, input ready);
    modport sink   (input valid, input kind, input payload_byte, input byte_index,
                    input frame_topic, input frame_length, input checksum_ok,
                    input route, input subscriber_slot, input errors_seen,
                    input link_connected, output ready);
endinterface

// ===== hw/rtl/serial_frame_parser.sv =====
// A request is held in the input register, parsed, and its result loaded into the result
// register on the result port. Throughput: one request per cycle while the result register
// is free; the parse step is one pass between the input register and the result register.
// Requests with no result (sync, header, polls) also wait for a free result register.
// Reset (rst_n low, asynchronous) returns the parser to sync search, clears
// the error count and link flag, and loads the register defaults.
// ---------------------------------------------------------------------------
// Serial frame parser
// Deframes a serial byte stream, forwards payload and reports each frame.
// ---------------------------------------------------------------------------
module serial_frame_parser
    import sfp_pkg::*;
#(
    parameter int MAX_PAYLOAD     = 512,
    parameter int MAX_SUBSCRIBERS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    sfp_byte_if.sink          stream,
    sfp_result_if.source      report,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t    cfg;
    logic    out_free;
    logic    advance;
    logic    res_vld;
    result_t res;

    sfp_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfp_parse_core #(
        .MAX_PAYLOAD     (MAX_PAYLOAD),
        .MAX_SUBSCRIBERS (MAX_SUBSCRIBERS)
    ) u_parse_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .stream   (stream),
        .cfg      (cfg),
        .out_free (out_free),
        .advance  (advance),
        .res_vld  (res_vld),
        .res      (res)
    );

    sfp_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .res_vld  (res_vld),
        .res      (res),
        .out_free (out_free),
        .report   (report)
    );

endmodule

// ===== hw/rtl/sfp_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// Serial frame parser configuration registers
// APB-style register file for topics, subscriber count, limit and timeout.
// ---------------------------------------------------------------------------
module sfp_cfg_regs
    import sfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.negotiation_topic <= RST_NEGOTIATION_TOPIC;
            cfg_reg.time_topic        <= RST_TIME_TOPIC;
            cfg_reg.param_topic       <= RST_PARAM_TOPIC;
            cfg_reg.receiver_count    <= RST_RECEIVER_COUNT;
            cfg_reg.payload_limit     <= RST_PAYLOAD_LIMIT;
            cfg_reg.timeout_ms        <= RST_TIMEOUT_MS;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_NEGOTIATION_TOPIC: cfg_reg.negotiation_topic <= pwdata[15:0];
                REG_TIME_TOPIC:        cfg_reg.time_topic        <= pwdata[15:0];
                REG_PARAM_TOPIC:       cfg_reg.param_topic       <= pwdata[15:0];
                REG_RECEIVER_COUNT:    cfg_reg.receiver_count    <= pwdata[5:0];
                REG_PAYLOAD_LIMIT:     cfg_reg.payload_limit     <= pwdata[9:0];
                REG_TIMEOUT_MS:        cfg_reg.timeout_ms        <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_NEGOTIATION_TOPIC: prdata = {16'd0, cfg_reg.negotiation_topic};
            REG_TIME_TOPIC:        prdata = {16'd0, cfg_reg.time_topic};
            REG_PARAM_TOPIC:       prdata = {16'd0, cfg_reg.param_topic};
            REG_RECEIVER_COUNT:    prdata = {26'd0, cfg_reg.receiver_count};
            REG_PAYLOAD_LIMIT:     prdata = {22'd0, cfg_reg.payload_limit};
            REG_TIMEOUT_MS:        prdata = {16'd0, cfg_reg.timeout_ms};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

// ===== hw/rtl/sfp_parse_core.sv =====
// ---------------------------------------------------------------------------
// Serial frame parser core
// Input register, frame state and single-pass parse step per request.
// ---------------------------------------------------------------------------
`include "serial_frame_parser_defines.svh"

module sfp_parse_core
    import sfp_pkg::*;
#(
    parameter int MAX_PAYLOAD     = 512,
    parameter int MAX_SUBSCRIBERS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    sfp_byte_if.sink   stream,
    input  cfg_t       cfg,
    input  logic       out_free,
    output logic       advance,
    output logic       res_vld,
    output result_t    res
);

    localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);
    localparam logic [8:0]  MAX_SUB = 9'(MAX_SUBSCRIBERS);

    logic        in_vld_reg;
    logic        in_mode_reg;
    logic [7:0]  in_byte_reg;
    logic [31:0] in_now_reg;

    phase_t      phase_reg,     phase_next;
    logic [15:0] topic_reg,     topic_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [9:0]  frame_len_reg, frame_len_next;
    logic [8:0]  pos_reg,       pos_next;
    logic [7:0]  sum_reg,       sum_next;
    logic [15:0] err_reg,       err_next;
    logic [31:0] start_reg,     start_next;
    logic [31:0] latched_reg,   latched_next;
    logic        conn_reg,      conn_next;

    logic        restart;
    logic        bump;
    logic [7:0]  sum_add;
    logic        stale;
    logic [15:0] len_c;
    logic [15:0] left_dec;
    logic [8:0]  slots;
    logic [15:0] sub_off;
    logic [2:0]  route_c;
    logic        ok_c;

    assign advance      = in_vld_reg && out_free;
    assign stream.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (stream.ready)
            in_vld_reg <= stream.valid;
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_mode_reg <= stream.mode;
            in_byte_reg <= stream.data_byte;
            in_now_reg  <= stream.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SYNC1;
            topic_reg      <= 16'd0;
            bytes_left_reg <= 16'd0;
            frame_len_reg  <= 10'd0;
            pos_reg        <= 9'd0;
            sum_reg        <= 8'd0;
            err_reg        <= 16'd0;
            start_reg      <= 32'd0;
            latched_reg    <= 32'd0;
            conn_reg       <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            topic_reg      <= topic_next;
            bytes_left_reg <= bytes_left_next;
            frame_len_reg  <= frame_len_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            err_reg        <= err_next;
            start_reg      <= start_next;
            latched_reg    <= latched_next;
            conn_reg       <= conn_next;
        end
    end

    assign sum_add  = sum_reg + in_byte_reg;
    assign stale    = ({1'b0, in_now_reg} > ({1'b0, start_reg} + {17'd0, cfg.timeout_ms}));
    assign len_c    = {in_byte_reg, bytes_left_reg[7:0]};
    assign left_dec = bytes_left_reg - 16'd1;
    assign slots    = ({3'd0, cfg.receiver_count} > MAX_SUB) ? MAX_SUB
                                                             : {3'd0, cfg.receiver_count};
    assign sub_off  = topic_reg - SUB_BASE;
    assign ok_c     = (sum_add == CHECK_GOOD);

    always_comb
    begin
        if (topic_reg == cfg.negotiation_topic)
            route_c = ROUTE_NEGOTIATION;
        else if (topic_reg == cfg.time_topic)
            route_c = ROUTE_TIME;
        else if (topic_reg == cfg.param_topic)
            route_c = ROUTE_PARAM;
        else if ((topic_reg >= SUB_BASE) && (sub_off < {7'd0, slots}))
            route_c = ROUTE_SUBSCRIBER;
        else
            route_c = ROUTE_UNKNOWN;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        topic_next      = topic_reg;
        bytes_left_next = bytes_left_reg;
        frame_len_next  = frame_len_reg;
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        start_next      = start_reg;
        latched_next    = latched_reg;
        conn_next       = conn_reg;
        restart         = 1'b0;
        bump            = 1'b0;
        res_vld         = 1'b0;
        res             = '0;

        if (advance)
        begin
            if (in_mode_reg == MODE_POLL)
            begin
                latched_next = in_now_reg;
                if ((start_reg != 32'd0) && stale)
                    restart = 1'b1;
            end
            else
            begin
                sum_next = sum_add;
                case (phase_reg)
                    PH_SYNC1:
                    begin
                        if (in_byte_reg == SYNC_BYTE)
                        begin
                            phase_next = PH_SYNC2;
                            start_next = latched_reg;
                        end
                        else
                            restart = 1'b1;
                    end
                    PH_SYNC2:
                    begin
                        if (in_byte_reg == SYNC_BYTE)
                            phase_next = PH_TOPIC_LO;
                        else
                            restart = 1'b1;
                    end
                    PH_TOPIC_LO:
                    begin
                        topic_next = {8'd0, in_byte_reg};
                        sum_next   = in_byte_reg;
                        phase_next = PH_TOPIC_HI;
                    end
                    PH_TOPIC_HI:
                    begin
                        topic_next = {in_byte_reg, topic_reg[7:0]};
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        bytes_left_next = {8'd0, in_byte_reg};
                        phase_next      = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        bytes_left_next = len_c;
                        if (len_c == 16'd0)
                        begin
                            frame_len_next = 10'd0;
                            phase_next     = PH_CHECK;
                        end
                        else if ((len_c <= {6'd0, cfg.payload_limit})
                                 && ({1'b0, len_c} <= MAX_LEN))
                        begin
                            frame_len_next = len_c[9:0];
                            pos_next       = 9'd0;
                            phase_next     = PH_DATA;
                        end
                        else
                        begin
                            restart = 1'b1;
                            bump    = 1'b1;
                        end
                    end
                    PH_DATA:
                    begin
                        res_vld          = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.payload_byte = in_byte_reg;
                        res.byte_index   = pos_reg;
                        pos_next         = pos_reg + 9'd1;
                        bytes_left_next  = left_dec;
                        if (left_dec == 16'd0)
                            phase_next = PH_CHECK;
                    end
                    PH_CHECK:
                    begin
                        res_vld          = 1'b1;
                        res.kind         = KIND_REPORT;
                        res.frame_topic  = topic_reg;
                        res.frame_length = frame_len_reg;
                        res.checksum_ok  = ok_c;
                        res.route        = route_c;
                        if (route_c == ROUTE_SUBSCRIBER)
                            res.subscriber_slot = sub_off[4:0];
                        if (ok_c && (route_c == ROUTE_NEGOTIATION))
                            conn_next = 1'b1;
                        if (ok_c && (route_c == ROUTE_UNKNOWN))
                            bump = 1'b1;
                        restart = 1'b1;
                    end
                    default:
                        restart = 1'b1;
                endcase
            end
        end

        if (restart)
        begin
            phase_next      = PH_SYNC1;
            topic_next      = 16'd0;
            bytes_left_next = 16'd0;
            frame_len_next  = 10'd0;
            pos_next        = 9'd0;
            sum_next        = 8'd0;
            start_next      = 32'd0;
        end

        err_next = (bump && (err_reg != ERR_MAX)) ? err_reg + 16'd1 : err_reg;

        if (res_vld && (res.kind == KIND_REPORT))
        begin
            res.errors_seen    = err_next;
            res.link_connected = conn_next;
        end
    end

    `SFP_ASSERT_NOW(a_report_from_check, clk, rst_n,
        res_vld && (res.kind == KIND_REPORT), phase_reg == PH_CHECK,
        "report issued outside checksum phase")
    `SFP_ASSERT_NOW(a_data_has_bytes, clk, rst_n,
        phase_reg == PH_DATA, bytes_left_reg != 16'd0,
        "payload phase with no bytes left")
    `SFP_ASSERT_NEXT(a_errors_monotonic, clk, rst_n,
        1'b1, err_reg >= $past(err_reg),
        "error count decreased")
    `SFP_ASSERT_NEXT(a_link_sticky, clk, rst_n,
        conn_reg, conn_reg,
        "link flag dropped")

endmodule

// ===== hw/rtl/sfp_out_stage.sv =====
// ---------------------------------------------------------------------------
// Serial frame parser result register
// Holds one result until the sink takes it; frees when taken or empty.
// ---------------------------------------------------------------------------
module sfp_out_stage
    import sfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic        res_vld,
    input  result_t     res,
    output logic        out_free,
    sfp_result_if.source report
);

    logic    vld_reg;
    result_t res_reg;

    assign out_free = !vld_reg || report.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (load)
            vld_reg <= res_vld;
        else if (report.ready)
            vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load && res_vld)
            res_reg <= res;
    end

    assign report.valid           = vld_reg;
    assign report.kind            = res_reg.kind;
    assign report.payload_byte    = res_reg.payload_byte;
    assign report.byte_index      = res_reg.byte_index;
    assign report.frame_topic     = res_reg.frame_topic;
    assign report.frame_length    = res_reg.frame_length;
    assign report.checksum_ok     = res_reg.checksum_ok;
    assign report.route           = res_reg.route;
    assign report.subscriber_slot = res_reg.subscriber_slot;
    assign report.errors_seen     = res_reg.errors_seen;
    assign report.link_connected  = res_reg.link_connected;

endmodule

// ===== verif/serial_frame_parser_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Serial frame parser checker
// Watches the byte, result and register ports, predicts every payload byte
// and frame report, and compares each result field by field in order.
// ---------------------------------------------------------------------------
module serial_frame_parser_checker
    import sfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    sfp_byte_if               stream,
    sfp_result_if             report,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                mismatches,
    output int                awaiting
);

    localparam int FRAME_MAX  = 512;
    localparam int SLOT_MAX   = 32;
    localparam int SHOW_LIMIT = 10;

    cfg_t        cfg;
    phase_t      phase;
    logic [15:0] topic;
    logic [15:0] bytes_left;
    logic [9:0]  frame_len;
    logic [8:0]  payload_pos;
    logic [7:0]  running_sum;
    logic [15:0] error_tally;
    logic [31:0] frame_start;
    logic [31:0] latched_ms;
    logic        connected;
    result_t     frame_outputs_due[$];

    task automatic restart_frame();
        phase       = PH_SYNC1;
        topic       = '0;
        bytes_left  = '0;
        frame_len   = '0;
        payload_pos = '0;
        running_sum = '0;
        frame_start = '0;
    endtask

    task automatic bump_errors();
        if (error_tally != ERR_MAX)
            error_tally++;
    endtask

    task automatic parse_request(input logic mode, input logic [7:0] b,
                                 input logic [31:0] now);
        result_t     r;
        logic [15:0] slots;
        r = '0;
        if (mode == MODE_POLL)
        begin
            latched_ms = now;
            if (frame_start != 0 &&
                {1'b0, now} > {1'b0, frame_start} + {17'd0, cfg.timeout_ms})
                restart_frame();
        end
        else
        begin
            running_sum = running_sum + b;
            case (phase)
                PH_SYNC1:
                begin
                    if (b == SYNC_BYTE)
                    begin
                        phase       = PH_SYNC2;
                        frame_start = latched_ms;
                    end
                    else
                        restart_frame();
                end
                PH_SYNC2:
                begin
                    if (b == SYNC_BYTE)
                        phase = PH_TOPIC_LO;
                    else
                        restart_frame();
                end
                PH_TOPIC_LO:
                begin
                    topic       = {8'h00, b};
                    running_sum = b;
                    phase       = PH_TOPIC_HI;
                end
                PH_TOPIC_HI:
                begin
                    topic[15:8] = b;
                    phase       = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    bytes_left = {8'h00, b};
                    phase      = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    bytes_left[15:8] = b;
                    if (bytes_left == 0)
                    begin
                        frame_len = '0;
                        phase     = PH_CHECK;
                    end
                    else if (bytes_left <= cfg.payload_limit && bytes_left <= FRAME_MAX)
                    begin
                        frame_len   = bytes_left[9:0];
                        payload_pos = '0;
                        phase       = PH_DATA;
                    end
                    else
                    begin
                        restart_frame();
                        bump_errors();
                    end
                end
                PH_DATA:
                begin
                    r.kind         = KIND_PAYLOAD;
                    r.payload_byte = b;
                    r.byte_index   = payload_pos;
                    frame_outputs_due.push_back(r);
                    payload_pos++;
                    bytes_left--;
                    if (bytes_left == 0)
                        phase = PH_CHECK;
                end
                default:
                begin
                    slots = (cfg.receiver_count > SLOT_MAX) ? 16'(SLOT_MAX)
                                                            : {10'd0, cfg.receiver_count};
                    r.kind         = KIND_REPORT;
                    r.frame_topic  = topic;
                    r.frame_length = frame_len;
                    r.checksum_ok  = (running_sum == CHECK_GOOD);
                    if (topic == cfg.negotiation_topic)
                        r.route = ROUTE_NEGOTIATION;
                    else if (topic == cfg.time_topic)
                        r.route = ROUTE_TIME;
                    else if (topic == cfg.param_topic)
                        r.route = ROUTE_PARAM;
                    else if (topic >= SUB_BASE && topic - SUB_BASE < slots)
                    begin
                        r.route           = ROUTE_SUBSCRIBER;
                        r.subscriber_slot = 5'(topic - SUB_BASE);
                    end
                    else
                        r.route = ROUTE_UNKNOWN;
                    if (r.checksum_ok)
                    begin
                        if (r.route == ROUTE_NEGOTIATION)
                            connected = 1'b1;
                        else if (r.route == ROUTE_UNKNOWN)
                            bump_errors();
                    end
                    r.errors_seen    = error_tally;
                    r.link_connected = connected;
                    frame_outputs_due.push_back(r);
                    restart_frame();
                end
            endcase
        end
    endtask

    function automatic string describe(result_t r);
        return $sformatf({"kind=%0d byte=%02h index=%0d topic=%04h length=%0d ok=%0d",
                          " route=%0d slot=%0d errors=%0d link=%0d"},
                         r.kind, r.payload_byte, r.byte_index, r.frame_topic,
                         r.frame_length, r.checksum_ok, r.route, r.subscriber_slot,
                         r.errors_seen, r.link_connected);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            cfg.negotiation_topic = RST_NEGOTIATION_TOPIC;
            cfg.time_topic        = RST_TIME_TOPIC;
            cfg.param_topic       = RST_PARAM_TOPIC;
            cfg.receiver_count    = RST_RECEIVER_COUNT;
            cfg.payload_limit     = RST_PAYLOAD_LIMIT;
            cfg.timeout_ms        = RST_TIMEOUT_MS;
            error_tally           = '0;
            latched_ms            = '0;
            connected             = 1'b0;
            restart_frame();
            frame_outputs_due.delete();
            mismatches            = 0;
            awaiting              = 0;
        end
        else
        begin
            if (report.valid && report.ready)
            begin
                got = {report.kind, report.payload_byte, report.byte_index,
                       report.frame_topic, report.frame_length, report.checksum_ok,
                       report.route, report.subscriber_slot, report.errors_seen,
                       report.link_connected};
                if (frame_outputs_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("unexpected result: %s", describe(got));
                end
                else
                begin
                    want = frame_outputs_due.pop_front();
                    if (got.kind !== want.kind ||
                        got.payload_byte !== want.payload_byte ||
                        got.byte_index !== want.byte_index ||
                        got.frame_topic !== want.frame_topic ||
                        got.frame_length !== want.frame_length ||
                        got.checksum_ok !== want.checksum_ok ||
                        got.route !== want.route ||
                        got.subscriber_slot !== want.subscriber_slot ||
                        got.errors_seen !== want.errors_seen ||
                        got.link_connected !== want.link_connected)
                    begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT)
                        begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(got));
                        end
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_NEGOTIATION_TOPIC: cfg.negotiation_topic = pwdata[15:0];
                    REG_TIME_TOPIC:        cfg.time_topic        = pwdata[15:0];
                    REG_PARAM_TOPIC:       cfg.param_topic       = pwdata[15:0];
                    REG_RECEIVER_COUNT:    cfg.receiver_count    = pwdata[5:0];
                    REG_PAYLOAD_LIMIT:     cfg.payload_limit     = pwdata[9:0];
                    REG_TIMEOUT_MS:        cfg.timeout_ms        = pwdata[15:0];
                    default: ;
                endcase
            end
            if (stream.valid && stream.ready)
                parse_request(stream.mode, stream.data_byte, stream.now_ms);
            awaiting = frame_outputs_due.size();
        end
    end

endmodule

// ===== verif/serial_frame_parser_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Serial frame parser testbench
// Sends polls, well-formed frames, broken frames and noise bytes under the reset
// register values, three written register settings and three handshake idling
// patterns; the checker predicts and compares every payload byte and frame report.
// ---------------------------------------------------------------------------
module serial_frame_parser_test;
    import sfp_pkg::*;

    localparam int FRAME_MAX     = 512;
    localparam int SETTLE_CYCLES = 8;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int          mismatches;
    int          awaiting;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          poll_pct;
    int          requests_sent;
    logic [31:0] sim_ms;
    cfg_t        applied;

    sfp_byte_if   rx_bytes ();
    sfp_result_if parsed ();

    serial_frame_parser uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (rx_bytes),
        .report  (parsed),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    serial_frame_parser_checker watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (rx_bytes),
        .report     (parsed),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        parsed.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            parsed.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("serial_frame_parser test failed");
        $finish;
    end

    task automatic push_request(input logic mode, input logic [7:0] b,
                                input logic [31:0] now);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            rx_bytes.valid <= 1'b0;
            @(negedge clk);
        end
        rx_bytes.valid     <= 1'b1;
        rx_bytes.mode      <= mode;
        rx_bytes.data_byte <= b;
        rx_bytes.now_ms    <= now;
        do
            @(posedge clk);
        while (!rx_bytes.ready);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic push_poll();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            sim_ms = sim_ms + $urandom_range(0, 3);
        else if (r < 97)
            sim_ms = sim_ms + applied.timeout_ms + $urandom_range(0, 3);
        else
            sim_ms = $urandom();
        push_request(MODE_POLL, 8'($urandom()), sim_ms);
    endtask

    task automatic push_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < poll_pct)
            push_poll();
        push_request(MODE_BYTE, b, $urandom());
    endtask

    // cut < 0 sends the whole frame
    task automatic send_frame(input logic [15:0] topic, input logic [15:0] len,
                              input bit good, input int cut);
        logic [7:0]  frame_bytes[$];
        logic [47:0] header;
        logic [7:0]  sum;
        logic [7:0]  b;
        int          k;
        int          count;
        header = {len[15:8], len[7:0], topic[15:8], topic[7:0], SYNC_BYTE, SYNC_BYTE};
        for (k = 0; k < 6; k++)
            frame_bytes.push_back(header[8*k +: 8]);
        sum = topic[7:0] + topic[15:8] + len[7:0] + len[15:8];
        if (len == 0 || (len <= applied.payload_limit && len <= FRAME_MAX))
        begin
            for (k = 0; k < len; k++)
            begin
                b = 8'($urandom());
                frame_bytes.push_back(b);
                sum = sum + b;
            end
            b = CHECK_GOOD - sum;
            if (!good)
                b = b + 8'($urandom_range(1, 255));
            frame_bytes.push_back(b);
        end
        count = (cut < 0 || cut > frame_bytes.size()) ? frame_bytes.size() : cut;
        for (k = 0; k < count; k++)
            push_byte(frame_bytes[k]);
    endtask

    task automatic drain();
        rx_bytes.valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
    endtask

    task automatic configure(input cfg_t c);
        drain();
        apb_write(REG_NEGOTIATION_TOPIC, {16'd0, c.negotiation_topic});
        apb_write(REG_TIME_TOPIC,        {16'd0, c.time_topic});
        apb_write(REG_PARAM_TOPIC,       {16'd0, c.param_topic});
        apb_write(REG_RECEIVER_COUNT,    {26'd0, c.receiver_count});
        apb_write(REG_PAYLOAD_LIMIT,     {22'd0, c.payload_limit});
        apb_write(REG_TIMEOUT_MS,        {16'd0, c.timeout_ms});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        applied = c;
    endtask

    function automatic logic [15:0] pick_topic();
        case ($urandom_range(0, 5))
            0:       return applied.negotiation_topic;
            1:       return applied.time_topic;
            2:       return applied.param_topic;
            3:       return SUB_BASE + 16'($urandom_range(0, 33));
            4:       return SUB_BASE - 16'd1;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 72)
            return 16'($urandom_range(0, 6));
        else if (r < 87)
            return 16'($urandom_range(7, 24));
        else if (r < 92)
            return (applied.payload_limit <= 64) ? {6'd0, applied.payload_limit}
                                                 : 16'($urandom_range(0, 6));
        else if (r < 97)
            return {6'd0, applied.payload_limit} + 16'd1;
        else
            return 16'($urandom());
    endfunction

    task automatic random_traffic(input int count);
        int stop;
        int r;
        stop = requests_sent + count;
        while (requests_sent < stop)
        begin
            r = $urandom_range(0, 99);
            if (r < 76)
                send_frame(pick_topic(), pick_length(), $urandom_range(0, 99) < 85, -1);
            else if (r < 86)
                send_frame(pick_topic(), 16'($urandom_range(0, 12)), 1'b1,
                           $urandom_range(1, 9));
            else if (r < 94)
                push_byte(8'($urandom()));
            else if (r < 97)
                push_byte(SYNC_BYTE);
            else if (r < 99)
                push_poll();
            else
                drain();
        end
    endtask

    initial
    begin
        cfg_t c;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        rx_bytes.valid     = 1'b0;
        rx_bytes.mode      = MODE_POLL;
        rx_bytes.data_byte = '0;
        rx_bytes.now_ms    = '0;
        send_idle_pct      = 21;
        recv_idle_pct      = 83;
        poll_pct           = 0;
        requests_sent      = 0;
        sim_ms             = '0;
        applied.negotiation_topic = RST_NEGOTIATION_TOPIC;
        applied.time_topic        = RST_TIME_TOPIC;
        applied.param_topic       = RST_PARAM_TOPIC;
        applied.receiver_count    = RST_RECEIVER_COUNT;
        applied.payload_limit     = RST_PAYLOAD_LIMIT;
        applied.timeout_ms        = RST_TIMEOUT_MS;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset register values: polls at time extremes, bad sync, frame kinds
        push_request(MODE_POLL, 8'h00, 32'hFFFF_FFFF);
        push_request(MODE_POLL, 8'hFF, 32'h0000_0000);
        push_byte(8'h00);
        send_frame(RST_NEGOTIATION_TOPIC, 16'd0, 1'b1, -1);
        send_frame(16'h1234, 16'hFFFF, 1'b1, -1);
        send_frame(RST_PARAM_TOPIC, 16'd1, 1'b0, -1);

        c.negotiation_topic = 16'd0;
        c.time_topic        = 16'hFFFF;
        c.param_topic       = RST_PARAM_TOPIC;
        c.receiver_count    = 6'd32;
        c.payload_limit     = 10'd512;
        c.timeout_ms        = 16'hFFFF;
        configure(c);
        send_frame(SUB_BASE + 16'd31, 16'd260, 1'b1, -1);
        poll_pct = 10;
        random_traffic(70);

        send_idle_pct = 83;
        recv_idle_pct = 21;
        c.negotiation_topic = 16'hFFFF;
        c.time_topic        = SUB_BASE;
        c.param_topic       = SUB_BASE + 16'd1;
        c.receiver_count    = 6'd0;
        c.payload_limit     = 10'd0;
        c.timeout_ms        = 16'd0;
        configure(c);
        random_traffic(70);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        c.negotiation_topic = 16'($urandom());
        c.time_topic        = 16'($urandom());
        c.param_topic       = 16'($urandom());
        c.receiver_count    = 6'($urandom_range(1, 31));
        c.payload_limit     = 10'($urandom_range(8, 40));
        c.timeout_ms        = 16'($urandom_range(1, 50));
        configure(c);
        random_traffic(70);

        drain();
        if (mismatches == 0 && awaiting == 0)
            $display("serial_frame_parser test passed");
        else
            $display("serial_frame_parser test failed");
        $finish;
    end

endmodule
